@@ src/chcs_pkg.sv @@
package chcs_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;

  localparam logic [CFG_IDX_W-1:0] CFG_SEARCH_SPEED    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SEARCH_NEGATIVE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STUCK_TIMEOUT   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_UNSTICK_HALF    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ANNOUNCE_PERIOD = 3'd4;

  localparam int CNT_W     = 32;
  localparam int HALF_W    = 16;
  localparam int DIV_STEPS = CNT_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

  typedef struct packed {
    logic               restart;
    logic               switch_level;
    logic signed [31:0] joint_position;
    logic signed [31:0] rising_edge_position;
    logic signed [31:0] falling_edge_position;
  } chcs_in_t;

  typedef struct packed {
    logic signed [15:0] steer_velocity;
    logic signed [31:0] zero_offset;
    logic               calibrated;
    logic               announce_pulse;
    logic               run_velocity_loop;
    logic [1:0]         phase;
  } chcs_out_t;

  typedef struct packed {
    logic              done;
    logic [HALF_W-1:0] rem;
    logic              qlsb;
  } chcs_div_res_t;

endpackage

@@ src/chcs_rediv.sv @@
module chcs_rediv (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [chcs_pkg::CNT_W-1:0]  dividend,
  input  logic [chcs_pkg::HALF_W-1:0] divisor,
  output logic                   busy,
  output chcs_pkg::chcs_div_res_t res
);
  import chcs_pkg::*;

  logic [DIV_CNT_W-1:0] cnt_r;
  logic [HALF_W-1:0]    acc_r;
  logic [CNT_W-1:0]     quo_r;
  logic [HALF_W-1:0]    dvs_r;

  logic [HALF_W:0]   sh;
  logic [HALF_W:0]   diff;
  logic              ge;
  logic [HALF_W-1:0] acc_nxt;

  // restoring division, one quotient bit per cycle, MSB first
  always_comb begin
    sh      = {acc_r, quo_r[CNT_W-1]};
    diff    = sh - {1'b0, dvs_r};
    ge      = sh >= {1'b0, dvs_r};
    acc_nxt = ge ? diff[HALF_W-1:0] : sh[HALF_W-1:0];
  end

  assign busy     = cnt_r != '0;
  assign res.done = cnt_r == DIV_CNT_W'(1);
  assign res.rem  = acc_nxt;
  assign res.qlsb = ge;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (start) begin
      cnt_r <= DIV_CNT_W'(DIV_STEPS);
    end else if (busy) begin
      cnt_r <= cnt_r - DIV_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc_r <= '0;
      quo_r <= dividend;
      dvs_r <= divisor;
    end else if (busy) begin
      acc_r <= acc_nxt;
      quo_r <= {quo_r[CNT_W-2:0], 1'b0};
    end
  end

  a_div_rem_below: assert property (@(posedge clk) disable iff (!rst_n)
    res.done |-> res.rem < dvs_r)
    else $error("division remainder not below divisor");

endmodule

@@ src/chcs_outbuf.sv @@
module chcs_outbuf (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  chcs_pkg::chcs_out_t push_data,
  output logic                full,
  output logic                out_valid,
  input  logic                out_stall,
  output chcs_pkg::chcs_out_t out_data
);
  import chcs_pkg::*;

  logic      main_valid_r;
  logic      skid_valid_r;
  chcs_out_t main_r;
  chcs_out_t skid_r;
  logic      pop;

  assign pop       = main_valid_r && !out_stall;
  assign full      = skid_valid_r;
  assign out_valid = main_valid_r;
  assign out_data  = main_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (pop) begin
        main_r       <= skid_r;
        skid_valid_r <= 1'b0;
      end
    end else if (push) begin
      if (!main_valid_r || pop) begin
        main_r       <= push_data;
        main_valid_r <= 1'b1;
      end else begin
        skid_r       <= push_data;
        skid_valid_r <= 1'b1;
      end
    end else if (pop) begin
      main_valid_r <= 1'b0;
    end
  end

  a_skid_behind_main: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> main_valid_r)
    else $error("skid entry held without main entry");

endmodule

@@ src/chcs_core.sv @@
module chcs_core (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [chcs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [chcs_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  chcs_pkg::chcs_in_t               in_data,
  input  logic                             buf_full,
  output logic                             push,
  output chcs_pkg::chcs_out_t              push_data
);
  import chcs_pkg::*;

  typedef enum logic [1:0] {
    PH_INIT  = 2'd0,
    PH_BEGIN = 2'd1,
    PH_MOVE  = 2'd2,
    PH_CAL   = 2'd3
  } phase_t;

  logic [12:0]       speed_r;
  logic              neg_r;
  logic [19:0]       timeout_r;
  logic [HALF_W-1:0] half_r;
  logic [19:0]       ann_per_r;

  logic               s1_valid_r;
  chcs_in_t           s1_r;
  phase_t             phase_r, phase_nxt;
  logic [CNT_W-1:0]   tick_r;
  logic [CNT_W-1:0]   move_start_r, move_start_nxt;
  logic [CNT_W-1:0]   last_ann_r, last_ann_nxt;
  logic               start_sw_r, start_sw_nxt;
  logic signed [31:0] start_pos_r, start_pos_nxt;
  logic signed [15:0] steer_r, steer_nxt;
  logic [CNT_W-1:0]   unstick_r, unstick_nxt;
  logic [HALF_W-1:0]  urem_r, urem_nxt;
  logic               upar_r, upar_nxt;
  logic signed [31:0] offset_r, offset_nxt;
  logic               announce;

  logic              div_start;
  logic              div_busy;
  chcs_div_res_t     div_res;
  logic [HALF_W-1:0] half_new;
  logic [HALF_W-1:0] half_eff;
  logic              accept;

  logic [15:0]       spd16;
  logic [15:0]       vel_begin;
  logic [15:0]       vel_move;
  logic [32:0]       pdiff;
  logic              d_neg, d_pos, st_pos, st_neg;
  logic [CNT_W-1:0]  elapsed, since_ann;
  logic [HALF_W-1:0] urem_inc;
  phase_t            ph_cur;

  assign div_start = cfg_we && cfg_index == CFG_UNSTICK_HALF;
  assign half_new  = (cfg_data[HALF_W-1:0] == '0) ? HALF_W'(1) : cfg_data[HALF_W-1:0];
  assign half_eff  = (half_r == '0) ? HALF_W'(1) : half_r;

  assign push     = s1_valid_r && !buf_full;
  assign in_stall = div_busy || div_start || (s1_valid_r && buf_full);
  assign accept   = in_valid && !in_stall;

  chcs_rediv u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (unstick_r),
    .divisor  (half_new),
    .busy     (div_busy),
    .res      (div_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speed_r   <= 13'd256;
      neg_r     <= 1'b0;
      timeout_r <= 20'd6000;
      half_r    <= 16'd1000;
      ann_per_r <= 20'd500;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SEARCH_SPEED:    speed_r   <= cfg_data[12:0];
        CFG_SEARCH_NEGATIVE: neg_r     <= cfg_data[0];
        CFG_STUCK_TIMEOUT:   timeout_r <= cfg_data[19:0];
        CFG_UNSTICK_HALF:    half_r    <= cfg_data[HALF_W-1:0];
        CFG_ANNOUNCE_PERIOD: ann_per_r <= cfg_data[19:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    spd16     = {3'b000, speed_r};
    vel_begin = (neg_r ^ s1_r.switch_level) ? 16'(-spd16) : spd16;
    vel_move  = (neg_r ^ start_sw_r) ? 16'(-spd16) : spd16;
    pdiff     = {s1_r.joint_position[31], s1_r.joint_position}
              - {start_pos_r[31], start_pos_r};
    d_neg     = pdiff[32];
    d_pos     = !pdiff[32] && pdiff != '0;
    st_neg    = steer_r[15];
    st_pos    = !steer_r[15] && steer_r != '0;
    elapsed   = tick_r - move_start_r;
    since_ann = tick_r - last_ann_r;
    urem_inc  = urem_r + HALF_W'(1);
    ph_cur    = s1_r.restart ? PH_INIT : phase_r;

    phase_nxt      = ph_cur;
    move_start_nxt = move_start_r;
    last_ann_nxt   = last_ann_r;
    start_sw_nxt   = start_sw_r;
    start_pos_nxt  = start_pos_r;
    steer_nxt      = steer_r;
    unstick_nxt    = unstick_r;
    urem_nxt       = urem_r;
    upar_nxt       = upar_r;
    offset_nxt     = s1_r.restart ? 32'sd0 : offset_r;
    announce       = 1'b0;

    case (ph_cur)
      PH_INIT: begin
        steer_nxt = '0;
        phase_nxt = PH_BEGIN;
      end
      PH_BEGIN: begin
        move_start_nxt = tick_r;
        start_sw_nxt   = s1_r.switch_level;
        start_pos_nxt  = s1_r.joint_position;
        steer_nxt      = vel_begin;
        phase_nxt      = PH_MOVE;
      end
      PH_MOVE: begin
        if (s1_r.switch_level != start_sw_r) begin
          if ((st_pos && d_neg) || (st_neg && d_pos)) begin
            phase_nxt = PH_BEGIN;
          end else begin
            offset_nxt = s1_r.switch_level ? s1_r.rising_edge_position
                                           : s1_r.falling_edge_position;
            phase_nxt  = PH_CAL;
            steer_nxt  = '0;
          end
        end else if (elapsed > CNT_W'(timeout_r)) begin
          steer_nxt   = upar_r ? 16'sd0 : {vel_move[13:0], 2'b00};
          unstick_nxt = unstick_r + CNT_W'(1);
          if (unstick_r == '1) begin
            urem_nxt = '0;
            upar_nxt = 1'b0;
          end else if (urem_inc == half_eff) begin
            urem_nxt = '0;
            upar_nxt = !upar_r;
          end else begin
            urem_nxt = urem_inc;
          end
        end else begin
          unstick_nxt = '0;
          urem_nxt    = '0;
          upar_nxt    = 1'b0;
        end
      end
      default: begin
        steer_nxt = '0;
        if (since_ann > CNT_W'(ann_per_r)) begin
          last_ann_nxt = tick_r;
          announce     = 1'b1;
        end
      end
    endcase

    push_data.steer_velocity    = steer_nxt;
    push_data.zero_offset       = offset_nxt;
    push_data.calibrated        = phase_nxt == PH_CAL;
    push_data.announce_pulse    = announce;
    push_data.run_velocity_loop = phase_nxt != PH_CAL;
    push_data.phase             = phase_nxt;
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      phase_r      <= PH_INIT;
      tick_r       <= '0;
      move_start_r <= '0;
      last_ann_r   <= '0;
      start_sw_r   <= 1'b0;
      start_pos_r  <= '0;
      steer_r      <= '0;
      unstick_r    <= '0;
      urem_r       <= '0;
      upar_r       <= 1'b0;
      offset_r     <= '0;
    end else begin
      if (accept) begin
        s1_valid_r <= 1'b1;
      end else if (push) begin
        s1_valid_r <= 1'b0;
      end
      if (push) begin
        phase_r      <= phase_nxt;
        tick_r       <= tick_r + CNT_W'(1);
        move_start_r <= move_start_nxt;
        last_ann_r   <= last_ann_nxt;
        start_sw_r   <= start_sw_nxt;
        start_pos_r  <= start_pos_nxt;
        steer_r      <= steer_nxt;
        unstick_r    <= unstick_nxt;
        urem_r       <= urem_nxt;
        upar_r       <= upar_nxt;
        offset_r     <= offset_nxt;
      end else if (div_res.done) begin
        urem_r <= div_res.rem;
        upar_r <= div_res.qlsb;
      end
    end
  end

  a_rem_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    !div_busy |-> urem_r < half_eff)
    else $error("unstick remainder out of range");

  a_restart_to_begin: assert property (@(posedge clk) disable iff (!rst_n)
    push && s1_r.restart |-> push_data.phase == PH_BEGIN && push_data.zero_offset == 0)
    else $error("restart did not return to begin with cleared offset");

  a_announce_cal: assert property (@(posedge clk) disable iff (!rst_n)
    push && push_data.announce_pulse |-> push_data.phase == PH_CAL)
    else $error("announce outside calibrated phase");

  a_cal_no_steer: assert property (@(posedge clk) disable iff (!rst_n)
    push && push_data.phase == PH_CAL |-> push_data.steer_velocity == 0)
    else $error("steer command while calibrated");

endmodule

@@ src/caster_homing_calibration_sequencer.sv @@
// An accepted item goes through the input register, then through the state
// update into the output register. Throughput: one item per cycle while
// in_stall is low; the output skid stage keeps input open. A write of the
// unstick half period starts a remainder division that holds in_stall
// high. Reset (rst_n low, synchronous) gives init phase.
module caster_homing_calibration_sequencer (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [chcs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [chcs_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  chcs_pkg::chcs_in_t              in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output chcs_pkg::chcs_out_t             out_data
);
  import chcs_pkg::*;

  logic      buf_full;
  logic      push;
  chcs_out_t push_data;

  chcs_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .buf_full  (buf_full),
    .push      (push),
    .push_data (push_data)
  );

  chcs_outbuf u_outbuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
